// ===== rtl/fvt_pkg.sv =====
package fvt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int HASH_BITS_DEF   = 64;

  localparam logic [2:0] ACT_RECORD     = 3'd0;
  localparam logic [2:0] ACT_ARCHIVE    = 3'd1;
  localparam logic [2:0] ACT_COPY       = 3'd2;
  localparam logic [2:0] ACT_RENAME     = 3'd3;
  localparam logic [2:0] ACT_APPROVE    = 3'd4;
  localparam logic [2:0] ACT_QUARANTINE = 3'd5;
  localparam logic [2:0] ACT_QUERY      = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] D_PENDING     = 2'd0;
  localparam logic [1:0] D_ALLOWED     = 2'd1;
  localparam logic [1:0] D_TRUSTED     = 2'd2;
  localparam logic [1:0] D_QUARANTINED = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] src_volume;
    logic [63:0] src_file;
    logic [31:0] src_stream;
    logic [63:0] src_provenance;
    logic [63:0] src_hash;
    logic [63:0] dst_volume;
    logic [63:0] dst_file;
    logic [31:0] dst_stream;
    logic [63:0] dst_provenance;
    logic [63:0] dst_hash;
    logic [31:0] reason_in;
  } fvt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        exec_allowed;
    logic [1:0]  disposition;
    logic [31:0] reason_out;
  } fvt_out_t;

  // one table entry as it sits in memory
  typedef struct packed {
    logic [63:0] volume;
    logic [63:0] file;
    logic [31:0] stream;
    logic [63:0] provenance;
    logic [63:0] hash;
    logic [1:0]  disposition;
    logic [31:0] reason;
  } fvt_entry_t;

endpackage

// ===== rtl/fvt_mem.sv =====
module fvt_mem import fvt_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic       clk,
  input  logic       we,
  input  logic [AW-1:0] waddr,
  input  fvt_entry_t wdata,
  input  logic [AW-1:0] raddr,
  output fvt_entry_t rdata
);

  fvt_entry_t mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/file_verdict_table_core.sv =====
// sequence: an accepted item passes through ISSUE, then SCAN, DECIDE and RESULT;
//   the result is registered in DECIDE and held in RESULT while out_stall is high
//   (a new item is taken only back in IDLE); the in-order scan of the table memory
//   reads one slot per cycle through one shared compare unit, up to the first match
// reset: synchronous active-high rst clears fill count and control state;
//   pending_reason returns to 1; table contents stay undefined until written
module file_verdict_table_core import fvt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int HASH_BITS   = HASH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  fvt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output fvt_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {IDLE, ISSUE, SCAN, DECIDE, RESULT} state_t;

  state_t      state;
  fvt_in_t     item;
  logic [31:0] pending_reason;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] idx;       // slot being compared
  logic [CW-1:0] ridx;      // slot being read
  logic        rvalid;
  logic        found, exact;
  logic [AW-1:0] hit_slot;
  fvt_entry_t  hit_entry;
  fvt_out_t    result;

  logic        we;
  logic [AW-1:0] waddr;
  fvt_entry_t  wdata;
  fvt_entry_t  rdata;

  logic [63:0] hmask;
  assign hmask = (HASH_BITS >= 64) ? '1 : ((64'd1 << HASH_BITS) - 64'd1);

  fvt_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(ridx[AW-1:0]), .rdata(rdata)
  );

  // shared compare unit on the slot just read
  logic ids_eq, hash_eq;
  assign ids_eq = rdata.volume == item.src_volume && rdata.file == item.src_file &&
                  rdata.stream == item.src_stream &&
                  rdata.provenance == item.src_provenance;
  assign hash_eq = rdata.hash == (item.src_hash & hmask);

  logic exact_only;
  assign exact_only = item.action == ACT_RENAME || item.action == ACT_APPROVE ||
                      item.action == ACT_QUARANTINE;

  assign in_stall  = state != IDLE;
  assign out_valid = state == RESULT;
  assign out_data  = result;
  assign cfg_ready = state == IDLE;

  // decision: lookup verdict, append or update
  logic [1:0]  ld;
  logic [31:0] lr;
  logic        full;
  assign ld = exact ? hit_entry.disposition : D_PENDING;
  assign lr = exact ? hit_entry.reason : pending_reason;
  assign full = fill_count == DEPTH_C;

  fvt_entry_t src_e, dst_e;
  always_comb begin
    src_e = '{item.src_volume, item.src_file, item.src_stream, item.src_provenance,
              item.src_hash & hmask, D_PENDING, pending_reason};
    dst_e = '{item.dst_volume, item.dst_file, item.dst_stream, item.dst_provenance,
              item.dst_hash & hmask, D_PENDING, pending_reason};
  end

  logic [1:0] st_d;
  logic       app_d, upd_d;
  fvt_entry_t wd_d;
  always_comb begin
    st_d = ST_OK;
    app_d = 1'b0;
    upd_d = 1'b0;
    wd_d = src_e;
    case (item.action)
      ACT_RECORD: app_d = 1'b1;
      ACT_ARCHIVE: begin
        if (!found) st_d = ST_NOT_FOUND;
        else if (ld != D_TRUSTED) begin
          app_d = 1'b1;
          wd_d = dst_e;
          wd_d.reason = lr | pending_reason;
        end
      end
      ACT_COPY: begin
        if (!found) st_d = ST_NOT_FOUND;
        else begin
          app_d = 1'b1;
          wd_d = dst_e;
          wd_d.disposition = ld;
          wd_d.reason = lr;
        end
      end
      ACT_RENAME: begin
        if (!found) st_d = ST_NOT_FOUND;
        else begin
          upd_d = 1'b1;
          wd_d = dst_e;
          wd_d.disposition = hit_entry.disposition;
          wd_d.reason = hit_entry.reason;
        end
      end
      ACT_APPROVE: begin
        if (!found) st_d = ST_NOT_FOUND;
        else begin
          upd_d = 1'b1;
          wd_d = hit_entry;
          wd_d.disposition = D_ALLOWED;
          wd_d.reason = '0;
        end
      end
      ACT_QUARANTINE: begin
        wd_d.disposition = D_QUARANTINED;
        wd_d.reason = item.reason_in;
        if (found) begin
          upd_d = 1'b1;
          wd_d = hit_entry;
          wd_d.disposition = D_QUARANTINED;
          wd_d.reason = item.reason_in;
        end else app_d = 1'b1;
      end
      ACT_QUERY: if (!found) st_d = ST_NOT_FOUND;
      default: ;
    endcase
    if (app_d && full) st_d = ST_FULL;
  end

  assign we    = state == DECIDE && ((app_d && !full) || upd_d);
  assign waddr = upd_d ? hit_slot : fill_count[AW-1:0];
  assign wdata = wd_d;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      fill_count <= '0;
      pending_reason <= 32'd1;
      rvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cfg_valid) pending_reason <= cfg_data;
          if (in_valid) begin
            item <= in_data;
            found <= 1'b0;
            exact <= 1'b0;
            ridx <= '0;
            idx <= '0;
            state <= ISSUE;
          end
        end
        ISSUE: begin
          rvalid <= ridx < fill_count;
          ridx <= ridx + 1'b1;
          state <= SCAN;
        end
        SCAN: begin
          if (rvalid && ids_eq && (hash_eq || !exact_only)) begin
            found <= 1'b1;
            exact <= hash_eq;
            hit_slot <= idx[AW-1:0];
            hit_entry <= rdata;
            rvalid <= 1'b0;
            state <= DECIDE;
          end else if (!rvalid) begin
            state <= DECIDE;
          end else begin
            rvalid <= ridx < fill_count;
            ridx <= ridx + 1'b1;
            idx <= idx + 1'b1;
          end
        end
        DECIDE: begin
          if (app_d && !full) fill_count <= fill_count + 1'b1;
          result.status <= st_d;
          result.exec_allowed <= item.action == ACT_QUERY && found &&
                                 (ld == D_ALLOWED || ld == D_TRUSTED);
          result.disposition <= (item.action == ACT_QUERY && found) ? ld : 2'd0;
          result.reason_out <= (item.action == ACT_QUERY && found) ? lr : 32'd0;
          state <= RESULT;
        end
        RESULT: if (!out_stall) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= DEPTH_C) else $error("fill count beyond depth");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    fill_count != $past(fill_count) |-> fill_count == $past(fill_count) + 1'b1)
    else $error("fill count jumped");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_full_st: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |-> full) else $error("bad full status");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fvt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  // verdict table predictor and queue of expected results
  class verdict_scoreboard;
    logic [31:0] pend_reason;
    bit          vld [DEPTH];
    logic [63:0] vol [DEPTH];
    logic [63:0] fil [DEPTH];
    logic [31:0] strm [DEPTH];
    logic [63:0] prov [DEPTH];
    logic [63:0] hsh [DEPTH];
    logic [1:0]  disp [DEPTH];
    logic [31:0] rsn [DEPTH];
    int          fill;
    fvt_out_t    pending_results[$];
    int          errors;

    function void clear();
      pend_reason = 32'd1;
      fill = 0;
      foreach (vld[i]) vld[i] = 0;
      pending_results.delete();
    endfunction

    function bit ids_eq(int i, logic [63:0] v, logic [63:0] f, logic [31:0] s,
                        logic [63:0] p);
      return vol[i] == v && fil[i] == f && strm[i] == s && prov[i] == p;
    endfunction

    function int find_exact(fvt_in_t it);
      for (int i = 0; i < fill; i++)
        if (vld[i] && ids_eq(i, it.src_volume, it.src_file, it.src_stream,
            it.src_provenance) && hsh[i] == it.src_hash) return i;
      return -1;
    endfunction

    function bit lookup(fvt_in_t it, output logic [1:0] d, output logic [31:0] r);
      d = D_PENDING;
      r = '0;
      for (int i = 0; i < fill; i++) begin
        if (vld[i] && ids_eq(i, it.src_volume, it.src_file, it.src_stream,
            it.src_provenance)) begin
          if (hsh[i] == it.src_hash) begin
            d = disp[i];
            r = rsn[i];
          end else begin
            d = D_PENDING;
            r = pend_reason;
          end
          return 1;
        end
      end
      return 0;
    endfunction

    function logic [1:0] append(logic [63:0] v, logic [63:0] f, logic [31:0] s,
                                logic [63:0] p, logic [63:0] h, logic [1:0] d,
                                logic [31:0] r);
      if (fill >= DEPTH) return ST_FULL;
      vol[fill] = v; fil[fill] = f; strm[fill] = s; prov[fill] = p;
      hsh[fill] = h; disp[fill] = d; rsn[fill] = r; vld[fill] = 1;
      fill++;
      return ST_OK;
    endfunction

    // note an accepted item and queue its expected result
    function void note_item(fvt_in_t it);
      fvt_out_t o;
      logic [1:0] d;
      logic [31:0] r;
      int s;
      o = '0;
      case (it.action)
        ACT_RECORD: o.status = append(it.src_volume, it.src_file, it.src_stream,
            it.src_provenance, it.src_hash, D_PENDING, pend_reason);
        ACT_ARCHIVE, ACT_COPY: begin
          if (!lookup(it, d, r)) o.status = ST_NOT_FOUND;
          else if (it.action == ACT_COPY)
            o.status = append(it.dst_volume, it.dst_file, it.dst_stream,
                it.dst_provenance, it.dst_hash, d, r);
          else if (d != D_TRUSTED)
            o.status = append(it.dst_volume, it.dst_file, it.dst_stream,
                it.dst_provenance, it.dst_hash, D_PENDING, r | pend_reason);
        end
        ACT_RENAME: begin
          s = find_exact(it);
          if (s < 0) o.status = ST_NOT_FOUND;
          else begin
            vol[s] = it.dst_volume; fil[s] = it.dst_file; strm[s] = it.dst_stream;
            prov[s] = it.dst_provenance; hsh[s] = it.dst_hash;
          end
        end
        ACT_APPROVE: begin
          s = find_exact(it);
          if (s < 0) o.status = ST_NOT_FOUND;
          else begin
            disp[s] = D_ALLOWED;
            rsn[s] = '0;
          end
        end
        ACT_QUARANTINE: begin
          s = find_exact(it);
          if (s < 0) o.status = append(it.src_volume, it.src_file, it.src_stream,
              it.src_provenance, it.src_hash, D_QUARANTINED, it.reason_in);
          else begin
            disp[s] = D_QUARANTINED;
            rsn[s] = it.reason_in;
          end
        end
        ACT_QUERY: begin
          if (!lookup(it, d, r)) o.status = ST_NOT_FOUND;
          else begin
            o.disposition = d;
            o.reason_out = r;
            o.exec_allowed = (d == D_ALLOWED || d == D_TRUSTED);
          end
        end
        default: ;
      endcase
      pending_results.insert(pending_results.size(), o);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(fvt_out_t got);
      fvt_out_t want;
      if (pending_results.size() == 0) begin
        report("unexpected item", 64'(got), 64'd0);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.exec_allowed !== want.exec_allowed)
        report("exec_allowed", 64'(got.exec_allowed), 64'(want.exec_allowed));
      if (got.disposition !== want.disposition)
        report("disposition", 64'(got.disposition), 64'(want.disposition));
      if (got.reason_out !== want.reason_out)
        report("reason_out", 64'(got.reason_out), 64'(want.reason_out));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  fvt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  fvt_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  verdict_scoreboard verdicts = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  file_verdict_table_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // receiver: random stall, check each accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) verdicts.check_result(out_data);
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // identity pool keeps lookups hitting
  fvt_in_t known[$];

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic fvt_in_t rand_ident_item(logic [2:0] act);
    fvt_in_t it;
    fvt_in_t k;
    it = fvt_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.action = act;
    if (known.size() > 0 && $urandom_range(99) < 75) begin
      k = known[$urandom_range(known.size() - 1)];
      it.src_volume = k.src_volume; it.src_file = k.src_file;
      it.src_stream = k.src_stream; it.src_provenance = k.src_provenance;
      it.src_hash = ($urandom_range(99) < 80) ? k.src_hash : rnd64();
    end else if ($urandom_range(1)) begin
      // small id space for collisions
      it.src_volume = 64'($urandom_range(3)); it.src_file = 64'($urandom_range(3));
      it.src_stream = $urandom_range(1); it.src_provenance = 64'($urandom_range(1));
      it.src_hash = 64'($urandom_range(3));
    end
    if ($urandom_range(1)) begin
      it.dst_volume = 64'($urandom_range(3)); it.dst_file = 64'($urandom_range(3));
      it.dst_stream = $urandom_range(1); it.dst_provenance = 64'($urandom_range(1));
      it.dst_hash = 64'($urandom_range(3));
    end
    return it;
  endfunction

  task automatic send_item(fvt_in_t it);
    fvt_in_t k;
    // valid is taken low between items
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdicts.note_item(it);
    k = it;
    known.insert(known.size(), k);
    k.src_volume = it.dst_volume; k.src_file = it.dst_file;
    k.src_stream = it.dst_stream; k.src_provenance = it.dst_provenance;
    k.src_hash = it.dst_hash;
    known.insert(known.size(), k);
    if (known.size() > 40) void'(known.pop_front());
    in_valid <= 0;
  endtask

  task automatic drain();
    while (verdicts.pending_results.size() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_pending_reason(logic [31:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    verdicts.pend_reason = v;
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int count);
    logic [2:0] act;
    for (int n = 0; n < count; n++) begin
      act = 3'($urandom_range(7));
      send_item(rand_ident_item(act));
    end
  endtask

  initial begin
    fvt_in_t it;
    verdicts.clear();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every action on a fresh table, extremes of fields
    it = '0;
    it.action = ACT_QUERY; send_item(it);
    it.action = ACT_ARCHIVE; send_item(it);
    it.action = ACT_COPY; send_item(it);
    it.action = ACT_RENAME; send_item(it);
    it.action = ACT_APPROVE; send_item(it);
    it.action = ACT_RECORD; send_item(it);
    it.action = ACT_QUERY; send_item(it);
    it.src_hash = '1; send_item(it);
    it = '1;
    it.action = ACT_QUARANTINE; send_item(it);
    it.action = ACT_QUERY; send_item(it);
    it.action = ACT_ARCHIVE; send_item(it);
    it.action = ACT_COPY; send_item(it);
    it.action = ACT_APPROVE; send_item(it);
    it.action = ACT_QUERY; send_item(it);
    it.action = ACT_RENAME; it.dst_volume = '0; send_item(it);
    it.action = 3'd7; send_item(it);
    // renamed entry now carries a zero volume; query the all-zero slot zero identity
    it = '0; it.action = ACT_QUERY; send_item(it);
    drain();

    write_pending_reason(32'hFFFF_FFFF);
    send_idle_pct = 27; recv_idle_pct = 82;
    random_phase(400);
    drain();

    // pressure: long receiver hold while the sender is held off by in_stall
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
      random_phase(30);
    join
    drain();

    // fill the table to exercise the full status
    write_pending_reason(32'h0);
    for (int n = 0; n < DEPTH + 4; n++) send_item(rand_ident_item(ACT_RECORD));
    drain();

    rst <= 0;
    write_pending_reason($urandom);
    send_idle_pct = 82; recv_idle_pct = 27;
    random_phase(400);
    drain();

    write_pending_reason(32'h8000_0001);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(450);
    drain();

    if (verdicts.errors == 0 && verdicts.pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
